/* rtl/k3f_pkg.sv */
// ----------------------------------------------------------------------------
// k3f_pkg: shared definitions for the 3x3 image filter
// Sizes, register indexes, kernel codes and the command record that passes
// from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package k3f_pkg;

  // Largest image the line stores and counters are built for.
  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 2048;
  localparam int MAX_CHANNELS = 4;

  // Counter and address widths follow from the limits above.
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int IDX_W      = $clog2(LINE_DEPTH);

  // One line store word holds the older row byte above the newer row byte.
  localparam int PIX_W      = 8;
  localparam int LINE_RAM_W = 2 * PIX_W;

  // Command queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd3;

  // Kernel selection; the fourth code gives all-zero results.
  typedef enum logic [1:0] {
    MODE_SHARPEN = 2'd0,
    MODE_EDGE    = 2'd1,
    MODE_BLUR    = 2'd2
  } mode_t;

  // Last valid position of each counter, after clamping the size registers.
  typedef struct packed {
    logic [ROW_W-1:0] row_last;
    logic [COL_W-1:0] col_last;
    logic [CH_W-1:0]  ch_last;
  } dims_t;

  // Result slots a sample may produce, lowest bit first in output order:
  // bit 0 the centred pixel up and left, bit 1 the right border pixel of the
  // row above, bit 2 the bottom border pixel to the left, bit 3 the corner.
  typedef struct packed {
    logic [PIX_W-1:0] sample;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CH_W-1:0]  chan;
    logic [IDX_W-1:0] idx;
    logic             kern_en;
    logic [3:0]       emits;
  } cmd_t;

endpackage

/* rtl/k3f_if.sv */
// ----------------------------------------------------------------------------
// k3f_if: stream channels of the 3x3 image filter
// Sample channel into the block and result channel out of it, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface k3f_in_if import k3f_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] sample;
  logic             frame_start;

  modport source (output valid, output sample, output frame_start, input ready);
  modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface k3f_out_if import k3f_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic [CH_W-1:0]  out_channel;
  logic             last;

  modport source (output valid, output value, output out_row, output out_col,
                  output out_channel, output last, input ready);
  modport sink   (input valid, input value, input out_row, input out_col,
                  input out_channel, input last, output ready);
endinterface

/* rtl/k3f_ram.sv */
// ----------------------------------------------------------------------------
// k3f_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered and holds while
// no read is issued.
// ----------------------------------------------------------------------------
module k3f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/k3f_queue.sv */
// ----------------------------------------------------------------------------
// k3f_queue: command queue between front and back end
// Small first-in first-out buffer of commands; the head is visible while the
// queue is not empty.
// ----------------------------------------------------------------------------
module k3f_queue import k3f_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("command queue count beyond depth");

  // The back end never takes a command from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("command queue popped while empty");

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("command queue pushed while full");

endmodule

/* rtl/k3f_front.sv */
// ----------------------------------------------------------------------------
// k3f_front: position tracking and classification
// Accepts samples, keeps the row, column and channel counters, and turns each
// sample into a command naming its line store address and its result slots.
// ----------------------------------------------------------------------------
module k3f_front import k3f_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  dims_t dims,
  k3f_in_if.sink pixels,
  input  logic  queue_full,
  output logic  push,
  output cmd_t  push_cmd
);

  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [CH_W-1:0]  chan_q;
  logic [ROW_W-1:0] row_next;
  logic [COL_W-1:0] col_next;
  logic [CH_W-1:0]  chan_next;

  logic [ROW_W-1:0] row_start;
  logic [COL_W-1:0] col_start;
  logic [CH_W-1:0]  chan_start;
  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c;
  logic [CH_W-1:0]  k;
  logic [CH_W:0]    nchan;
  logic             col_edge;
  logic             row_edge;

  assign pixels.ready = !queue_full;
  assign push         = pixels.valid && !queue_full;

  // Frame start and out-of-range counters restart at zero.
  always_comb begin
    row_start  = pixels.frame_start ? '0 : row_q;
    col_start  = pixels.frame_start ? '0 : col_q;
    chan_start = pixels.frame_start ? '0 : chan_q;
    k = (chan_start > dims.ch_last)  ? '0 : chan_start;
    c = (col_start  > dims.col_last) ? '0 : col_start;
    r = (row_start  > dims.row_last) ? '0 : row_start;
  end

  // Line store address and result slots of this sample.
  always_comb begin
    nchan    = {1'b0, dims.ch_last} + 1'b1;
    col_edge = (c == dims.col_last);
    row_edge = (r == dims.row_last);

    push_cmd.sample   = pixels.sample;
    push_cmd.row      = r;
    push_cmd.col      = c;
    push_cmd.chan     = k;
    push_cmd.idx      = IDX_W'(c) * IDX_W'(nchan) + IDX_W'(k);
    push_cmd.kern_en  = (r >= ROW_W'(2)) && (c >= COL_W'(2));
    push_cmd.emits[0] = (r != '0) && (c != '0);
    push_cmd.emits[1] = (r != '0) && col_edge;
    push_cmd.emits[2] = row_edge && (c != '0);
    push_cmd.emits[3] = row_edge && col_edge;
  end

  // Advance channel, then column, then row.
  always_comb begin
    row_next  = r;
    col_next  = c;
    chan_next = k + 1'b1;
    if (k == dims.ch_last) begin
      chan_next = '0;
      col_next  = c + 1'b1;
      if (col_edge) begin
        col_next = '0;
        row_next = row_edge ? '0 : r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_q  <= '0;
      col_q  <= '0;
      chan_q <= '0;
    end else if (push) begin
      row_q  <= row_next;
      col_q  <= col_next;
      chan_q <= chan_next;
    end
  end

endmodule

/* rtl/k3f_back.sv */
// ----------------------------------------------------------------------------
// k3f_back: line stores, window and kernel arithmetic
// Reads the two rows above from the line stores, forms the 3x3 window of the
// sample's channel, applies the selected kernel, and hands out the up to four
// results of each command through an output register.
// ----------------------------------------------------------------------------
module k3f_back import k3f_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  mode_t mode,
  input  logic  empty,
  input  cmd_t  head,
  output logic  pop,
  k3f_out_if.source results
);

  // Pipeline control.
  logic adv;
  logic out_load;

  // Read stage.
  logic                  b1_valid;
  cmd_t                  b1_cmd;
  logic [LINE_RAM_W-1:0] rd_data;
  logic                  fwd_hit;
  logic [PIX_W-1:0]      fwd_top;
  logic [PIX_W-1:0]      fwd_mid;
  logic [PIX_W-1:0]      top;
  logic [PIX_W-1:0]      mid;
  logic [PIX_W-1:0]      win [MAX_CHANNELS][2][3];
  logic [PIX_W+1:0]      edges_sum;
  logic [PIX_W+1:0]      corners_sum;

  // Kernel stage.
  logic             b2_valid;
  cmd_t             b2_cmd;
  logic [PIX_W+1:0] b2_edges;
  logic [PIX_W+1:0] b2_corners;
  logic [PIX_W-1:0] b2_center;
  logic [12:0]      c13;
  logic [12:0]      e13;
  logic [12:0]      k13;
  logic [12:0]      sharp;
  logic [12:0]      edge_v;
  logic [12:0]      blur_sum;
  logic [8:0]       blur_q;
  logic [PIX_W-1:0] kern_val;

  // Result stage.
  logic [3:0]       x_mask;
  logic [3:0]       pick;
  logic [3:0]       rest;
  logic [PIX_W-1:0] x_value;
  logic [ROW_W-1:0] x_row;
  logic [COL_W-1:0] x_col;
  logic [CH_W-1:0]  x_chan;
  logic [PIX_W-1:0] res_value;
  logic [ROW_W-1:0] res_row;
  logic [COL_W-1:0] res_col;

  // Output register.
  logic             out_valid;
  logic [PIX_W-1:0] out_value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic [CH_W-1:0]  out_chan;
  logic             out_last;

  function automatic logic [PIX_W-1:0] clamp_byte(input logic [12:0] v);
    logic [PIX_W-1:0] res;
    if (v[12]) begin
      res = '0;
    end else if (v[11:8] != 4'd0) begin
      res = '1;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  // The whole back end moves when the result stage is free or frees up now.
  assign pick     = x_mask & (~x_mask + 4'd1);
  assign rest     = x_mask & ~pick;
  assign out_load = (x_mask != 4'd0) && (!out_valid || results.ready);
  assign adv      = (x_mask == 4'd0) || (out_load && (rest == 4'd0));
  assign pop      = adv && !empty;

  // Line stores: older row in the upper byte, newer row in the lower byte.
  k3f_ram #(
    .WIDTH (LINE_RAM_W),
    .DEPTH (LINE_DEPTH)
  ) u_lines (
    .clk   (clk),
    .we    (adv && b1_valid),
    .waddr (b1_cmd.idx),
    .wdata ({mid, b1_cmd.sample}),
    .re    (pop),
    .raddr (head.idx),
    .rdata (rd_data)
  );

  // A command at the address being written this cycle takes the new bytes.
  assign top = fwd_hit ? fwd_top : rd_data[LINE_RAM_W-1:PIX_W];
  assign mid = fwd_hit ? fwd_mid : rd_data[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (adv) begin
      b1_valid <= pop;
      fwd_hit  <= pop && b1_valid && (b1_cmd.idx == head.idx);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_cmd  <= head;
      fwd_top <= mid;
      fwd_mid <= b1_cmd.sample;
    end
  end

  // Window sums: left and centre columns from the window, right from the row.
  always_comb begin
    edges_sum = (PIX_W + 2)'(win[b1_cmd.chan][0][1]) + (PIX_W + 2)'(mid)
              + (PIX_W + 2)'(win[b1_cmd.chan][1][0])
              + (PIX_W + 2)'(win[b1_cmd.chan][1][2]);
    corners_sum = (PIX_W + 2)'(win[b1_cmd.chan][0][0]) + (PIX_W + 2)'(top)
                + (PIX_W + 2)'(win[b1_cmd.chan][0][2])
                + (PIX_W + 2)'(b1_cmd.sample);
  end

  // Shift the channel's window by one column.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
        for (int cl = 0; cl < 2; cl++) begin
          for (int rw = 0; rw < 3; rw++) begin
            win[ch][cl][rw] <= '0;
          end
        end
      end
    end else if (adv && b1_valid) begin
      for (int rw = 0; rw < 3; rw++) begin
        win[b1_cmd.chan][0][rw] <= win[b1_cmd.chan][1][rw];
      end
      win[b1_cmd.chan][1][0] <= top;
      win[b1_cmd.chan][1][1] <= mid;
      win[b1_cmd.chan][1][2] <= b1_cmd.sample;
    end
  end

  // Kernel stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else if (adv) begin
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_cmd     <= b1_cmd;
      b2_edges   <= edges_sum;
      b2_corners <= corners_sum;
      b2_center  <= win[b1_cmd.chan][1][1];
    end
  end

  // Kernel arithmetic in 13-bit two's complement.
  always_comb begin
    c13      = 13'(b2_center);
    e13      = 13'(b2_edges);
    k13      = 13'(b2_corners);
    sharp    = (c13 << 2) + c13 - e13;
    edge_v   = (c13 << 3) - e13 - k13;
    blur_sum = (c13 << 2) + (e13 << 1) + k13;
    blur_q   = blur_sum[12:4];
    // Round to nearest, ties to even.
    if ((blur_sum[3:0] > 4'd8) || ((blur_sum[3:0] == 4'd8) && blur_q[0])) begin
      blur_q = blur_q + 1'b1;
    end
    case (mode)
      MODE_SHARPEN: kern_val = clamp_byte(sharp);
      MODE_EDGE:    kern_val = clamp_byte(edge_v);
      MODE_BLUR:    kern_val = blur_q[8] ? '1 : blur_q[7:0];
      default:      kern_val = '0;
    endcase
    if (!b2_cmd.kern_en) begin
      kern_val = '0;
    end
  end

  // Result stage: holds the slots still to be sent for one command.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_mask <= '0;
    end else if (adv) begin
      x_mask <= b2_valid ? b2_cmd.emits : 4'd0;
    end else if (out_load) begin
      x_mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_value <= kern_val;
      x_row   <= b2_cmd.row;
      x_col   <= b2_cmd.col;
      x_chan  <= b2_cmd.chan;
    end
  end

  // Position and value of the slot sent next.
  always_comb begin
    case (pick)
      4'b0001: begin
        res_value = x_value;
        res_row   = x_row - 1'b1;
        res_col   = x_col - 1'b1;
      end
      4'b0010: begin
        res_value = '0;
        res_row   = x_row - 1'b1;
        res_col   = x_col;
      end
      4'b0100: begin
        res_value = '0;
        res_row   = x_row;
        res_col   = x_col - 1'b1;
      end
      default: begin
        res_value = '0;
        res_row   = x_row;
        res_col   = x_col;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= res_value;
      out_row   <= res_row;
      out_col   <= res_col;
      out_chan  <= x_chan;
      out_last  <= (rest == 4'd0);
    end
  end

  assign results.valid       = out_valid;
  assign results.value       = out_value;
  assign results.out_row     = out_row;
  assign results.out_col     = out_col;
  assign results.out_channel = out_chan;
  assign results.last        = out_last;

  // Exactly one slot is chosen while any remain.
  a_pick_onehot: assert property (@(posedge clk) disable iff (rst)
    (x_mask != 4'd0) |-> $onehot(pick))
    else $error("result slot pick is not one-hot");

  // The pipe never moves over a command with unsent results.
  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    ((x_mask != 4'd0) && !out_load) |-> !adv)
    else $error("back end advanced over pending results");

  // Every line store read lands in a valid read stage.
  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    pop |=> b1_valid)
    else $error("line store read without a command in the read stage");

endmodule

/* rtl/kernel_3x3_image_filter.sv */
// ----------------------------------------------------------------------------
// kernel_3x3_image_filter: streaming 3x3 sharpen, edge and blur filter
// Top level: configuration registers, front end, command queue, back end.
// ----------------------------------------------------------------------------
// Channel bytes enter on pixels in raster order, interleaved by channel, one
// request per sample; frame_start marks the first sample of a frame. Results
// leave on results as filtered bytes with their row, column and channel, and
// last marks the final result a sample caused. Each result is centred on its
// pixel; the first and last rows and columns come out as zero.
// A sample is taken every clock cycle while the command queue has room. The
// first result of a sample passes the queue, the line store read, the window
// sums, the kernel and rounding and the output register, each registered. The
// back end sends one result per cycle while the receiver is ready, so samples
// with a single result flow at one per cycle; a sample at the last column or
// in the last row gives up to four results and holds the back end while it
// sends each extra one, which the four-entry queue buffers until it fills.
// Reset clears the position counters and the window and loads the default
// size of 640 x 480 with three channels and the sharpen kernel; line store
// contents are not cleared, and bytes read before they are written never
// reach a result.
// When the receiver stalls, the output register holds its request, the back
// end stops, the queue fills and pixels.ready drops. The user writes registers
// via cfg_en, cfg_index and cfg_data only while idle; the block does not check.
// ----------------------------------------------------------------------------
module kernel_3x3_image_filter import k3f_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  k3f_in_if.sink                pixels,
  k3f_out_if.source             results
);

  logic [1:0]  mode_q;
  logic [11:0] width_q;
  logic [11:0] height_q;
  logic [2:0]  channels_q;
  dims_t       dims;

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic queue_empty;
  logic pop;
  cmd_t head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q     <= MODE_SHARPEN;
      width_q    <= 12'd640;
      height_q   <= 12'd480;
      channels_q <= 3'd3;
    end else if (cfg_en) begin
      case (cfg_index)
        CFG_MODE:     mode_q     <= cfg_data[1:0];
        CFG_WIDTH:    width_q    <= cfg_data[11:0];
        CFG_HEIGHT:   height_q   <= cfg_data[11:0];
        CFG_CHANNELS: channels_q <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Sizes clamped to the supported range, as last counter positions.
  always_comb begin
    if (width_q < 12'd3) begin
      dims.col_last = COL_W'(2);
    end else if (32'(width_q) > MAX_WIDTH) begin
      dims.col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      dims.col_last = COL_W'(width_q - 12'd1);
    end
    if (height_q < 12'd3) begin
      dims.row_last = ROW_W'(2);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      dims.row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      dims.row_last = ROW_W'(height_q - 12'd1);
    end
    if (channels_q == 3'd0) begin
      dims.ch_last = CH_W'(0);
    end else if (32'(channels_q) > MAX_CHANNELS) begin
      dims.ch_last = CH_W'(MAX_CHANNELS - 1);
    end else begin
      dims.ch_last = CH_W'(channels_q - 3'd1);
    end
  end

  k3f_front u_front (
    .clk        (clk),
    .rst        (rst),
    .dims       (dims),
    .pixels     (pixels),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  k3f_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head     (head)
  );

  k3f_back u_back (
    .clk     (clk),
    .rst     (rst),
    .mode    (mode_t'(mode_q)),
    .empty   (queue_empty),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule
